@@ rtl/tcse_pkg.sv @@
// Shared types, constants and field widths for the text console scrollback engine.
package tcse_pkg;

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int LINES_W = 8;
    localparam int RROW_W  = 7;
    localparam int RCOL_W  = 7;
    localparam int OROW_W  = 7;
    localparam int OCOL_W  = 7;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CHAR_W + COLOR_W;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int DEF_WINDOW_ROWS     = 25;
    localparam int DEF_WINDOW_COLS     = 80;
    localparam int DEF_SCROLLBACK_ROWS = 100;

    localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
    localparam logic [COLOR_W-1:0] BLANK_COLOR  = 8'h0f;

    localparam logic REG_IDX_TEXT_COLOR = 1'b0;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_WIPE,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic wipe;
        logic read;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_wipe;
        logic wipe_last;
    } t_dp_stat;

endpackage

@@ rtl/tcse_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface tcse_in_if;
    import tcse_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [CHAR_W-1:0]          char_code;
    logic signed [LINES_W-1:0]  scroll_lines;
    logic [RROW_W-1:0]          read_row;
    logic [RCOL_W-1:0]          read_col;

    modport source (output valid, kind, char_code, scroll_lines, read_row, read_col,
                    input ready);
    modport sink   (input valid, kind, char_code, scroll_lines, read_row, read_col,
                    output ready);
endinterface

interface tcse_out_if;
    import tcse_pkg::*;

    logic               valid;
    logic               ready;
    logic [OROW_W-1:0]  cursor_row;
    logic [OCOL_W-1:0]  cursor_col;
    logic [OROW_W-1:0]  window_top;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;

    modport source (output valid, cursor_row, cursor_col, window_top, cell_char, cell_color,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, window_top, cell_char, cell_color,
                    output ready);
endinterface

@@ rtl/tcse_ctrl.sv @@
// Controller state machine: sequences accept, update, row wipe, cell read and result load.
module tcse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcse_pkg::t_dp_cmd  o_cmd,
    input  tcse_pkg::t_dp_stat i_stat
);
    import tcse_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: if (i_stat.wipe_last) n_state = S_IDLE;
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = i_stat.need_wipe ? S_WIPE : S_READ;
            S_WIPE: if (i_stat.wipe_last) n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: if (out_free) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: o_cmd.wipe = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_WIPE: o_cmd.wipe = 1'b1;
            S_READ: o_cmd.read = 1'b1;
            S_LOAD: o_cmd.load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_EXEC)
        else $error("accepted transaction did not start an update");

    a_exec_no_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !i_stat.need_wipe) |=> r_state == S_READ)
        else $error("update without freed rows did not go to cell read");

    a_wipe_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIPE && i_stat.wipe_last) |=> r_state == S_READ)
        else $error("row wipe did not end on its last cell");

    a_read_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> r_state == S_LOAD)
        else $error("cell read not followed by result load");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

@@ rtl/tcse_datapath.sv @@
// Datapath: cursor and window registers, ring-addressed cell store, wipe counters, result register.
module tcse_datapath #(
    parameter int WINDOW_ROWS     = tcse_pkg::DEF_WINDOW_ROWS,
    parameter int WINDOW_COLS     = tcse_pkg::DEF_WINDOW_COLS,
    parameter int SCROLLBACK_ROWS = tcse_pkg::DEF_SCROLLBACK_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcse_pkg::t_dp_cmd                 i_cmd,
    output tcse_pkg::t_dp_stat                o_stat,
    input  logic [tcse_pkg::COLOR_W-1:0]      i_text_color,
    input  logic [tcse_pkg::KIND_W-1:0]       i_kind,
    input  logic [tcse_pkg::CHAR_W-1:0]       i_char_code,
    input  logic signed [tcse_pkg::LINES_W-1:0] i_scroll_lines,
    input  logic [tcse_pkg::RROW_W-1:0]       i_read_row,
    input  logic [tcse_pkg::RCOL_W-1:0]       i_read_col,
    output logic [tcse_pkg::OROW_W-1:0]       o_cursor_row,
    output logic [tcse_pkg::OCOL_W-1:0]       o_cursor_col,
    output logic [tcse_pkg::OROW_W-1:0]       o_window_top,
    output logic [tcse_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [tcse_pkg::COLOR_W-1:0]      o_cell_color
);
    import tcse_pkg::*;

    localparam int R      = SCROLLBACK_ROWS;
    localparam int W      = WINDOW_ROWS;
    localparam int C      = WINDOW_COLS;
    localparam int ROW_W  = $clog2(R);
    localparam int CNT_W  = $clog2(R + 1);
    localparam int COL_W  = $clog2(C);
    localparam int DEPTH  = R * C;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOP    = (R > W) ? R - W : 0;
    localparam int WIDE_W = (ROW_W > LINES_W - 1) ? ROW_W : LINES_W - 1;
    localparam int SUM_W  = WIDE_W + 2;
    localparam int BOT_W  = ((ROW_W > 7) ? ROW_W : 7) + 1;
    localparam int RR_W   = (CNT_W > RROW_W) ? CNT_W : RROW_W;
    localparam int CC_W   = ($clog2(C + 1) > RCOL_W) ? $clog2(C + 1) : RCOL_W;

    function automatic logic [ROW_W-1:0] ring_add(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
        logic [ROW_W:0] s;
        s = (ROW_W+1)'(a) + (ROW_W+1)'(b);
        if (s >= (ROW_W+1)'(R)) begin
            s = s - (ROW_W+1)'(R);
        end
        return ROW_W'(s);
    endfunction

    // captured transaction
    logic [KIND_W-1:0]         r_kind;
    logic [CHAR_W-1:0]         r_char;
    logic signed [LINES_W-1:0] r_lines;
    logic [RROW_W-1:0]         r_rrow;
    logic [RCOL_W-1:0]         r_rcol;

    logic [ROW_W-1:0] r_cr, n_cr;
    logic [COL_W-1:0] r_cc, n_cc;
    logic [ROW_W-1:0] r_wt, n_wt;
    logic [ROW_W-1:0] r_base, n_base;

    logic [ROW_W-1:0] r_wipe_row;
    logic [COL_W-1:0] r_wipe_col;
    logic [CNT_W-1:0] r_wipe_left;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;
    logic              r_rd_ok;

    logic [OROW_W-1:0]  r_o_crow;
    logic [OCOL_W-1:0]  r_o_ccol;
    logic [OROW_W-1:0]  r_o_wtop;
    logic [CHAR_W-1:0]  r_o_char;
    logic [COLOR_W-1:0] r_o_color;

    // row advance
    logic [ROW_W:0]   cr1, cr2;
    logic [BOT_W-1:0] bottom;
    logic             hit, at_top, nr_shift;
    logic [ROW_W-1:0] wt_nr;

    // window scroll
    logic signed [SUM_W-1:0] wt_s, lines_s, tgt, top_s;
    logic [SUM_W-1:0]        n_sc;
    logic [ROW_W-1:0]        cr_sc;
    logic                    neg, over;

    logic [SUM_W-1:0] shift_n;
    logic [CNT_W-1:0] wipe_m;
    logic             put_wr;
    logic [ROW_W-1:0] cur_phys, rd_phys, acc_row;
    logic [COL_W-1:0] acc_col;
    logic [ADDR_W-1:0] addr;
    logic             we, rd_ok;
    logic [CELL_W-1:0] wdata;

    always_comb begin
        cr1    = (ROW_W+1)'(r_cr) + 1'b1;
        bottom = BOT_W'(r_wt) + BOT_W'(W);
        hit    = BOT_W'(cr1) == bottom;
        at_top = r_wt >= ROW_W'(TOP);
        nr_shift = 1'b0;
        cr2    = cr1;
        wt_nr  = r_wt;
        if (hit && at_top) begin
            nr_shift = 1'b1;
            cr2      = cr1 - 1'b1;
            wt_nr    = ROW_W'(TOP);
        end else if (hit) begin
            wt_nr = r_wt + 1'b1;
        end
        if (cr2 >= (ROW_W+1)'(R)) begin
            nr_shift = 1'b1;
            cr2      = (ROW_W+1)'(R - 1);
        end
    end

    always_comb begin
        wt_s    = SUM_W'(r_wt);
        lines_s = {{(SUM_W-LINES_W){r_lines[LINES_W-1]}}, r_lines};
        top_s   = SUM_W'(TOP);
        tgt     = wt_s + lines_s;
        neg     = tgt[SUM_W-1];
        over    = !neg && (tgt > top_s);
        n_sc    = SUM_W'(tgt - top_s);
        cr_sc   = (SUM_W'(r_cr) > n_sc) ? ROW_W'(SUM_W'(r_cr) - n_sc) : '0;
    end

    always_comb begin
        n_cr    = r_cr;
        n_cc    = r_cc;
        n_wt    = r_wt;
        shift_n = '0;
        put_wr  = 1'b0;
        case (r_kind)
            KIND_PUT: begin
                case (r_char)
                    CH_NEWLINE: begin
                        n_cr    = ROW_W'(cr2);
                        n_wt    = wt_nr;
                        shift_n = SUM_W'(nr_shift);
                    end
                    CH_RETURN:    n_cc = '0;
                    CH_BACKSPACE: n_cc = (r_cc != '0) ? r_cc - 1'b1 : r_cc;
                    default: begin
                        put_wr = 1'b1;
                        if (r_cc == COL_W'(C - 1)) begin
                            n_cc    = '0;
                            n_cr    = ROW_W'(cr2);
                            n_wt    = wt_nr;
                            shift_n = SUM_W'(nr_shift);
                        end else begin
                            n_cc = r_cc + 1'b1;
                        end
                    end
                endcase
            end
            KIND_SCROLL: begin
                if (neg) begin
                    n_wt = '0;
                end else if (over) begin
                    n_wt    = ROW_W'(TOP);
                    n_cr    = cr_sc;
                    shift_n = n_sc;
                end else begin
                    n_wt = ROW_W'(tgt);
                end
            end
            default: n_wt = r_wt;
        endcase
    end

    // freed rows are the oldest ones, starting at the current ring base
    always_comb begin
        if (shift_n >= SUM_W'(R)) begin
            wipe_m = CNT_W'(R);
            n_base = r_base;
        end else begin
            wipe_m = CNT_W'(shift_n);
            n_base = ring_add(r_base, ROW_W'(shift_n));
        end
    end

    assign o_stat.need_wipe = shift_n != '0;
    assign o_stat.wipe_last = (r_wipe_left == CNT_W'(1)) && (r_wipe_col == COL_W'(C - 1));

    assign cur_phys = ring_add(r_cr, r_base);
    assign rd_phys  = ring_add(ROW_W'(r_rrow), r_base);
    assign rd_ok    = (RR_W'(r_rrow) < RR_W'(R)) && (CC_W'(r_rcol) < CC_W'(C));

    always_comb begin
        if (i_cmd.wipe) begin
            acc_row = r_wipe_row;
            acc_col = r_wipe_col;
        end else if (i_cmd.read) begin
            acc_row = rd_ok ? rd_phys : '0;
            acc_col = rd_ok ? COL_W'(r_rcol) : '0;
        end else begin
            acc_row = cur_phys;
            acc_col = r_cc;
        end
        addr  = ADDR_W'(ADDR_W'(acc_row) * ADDR_W'(C) + ADDR_W'(acc_col));
        we    = i_cmd.wipe || (i_cmd.exec && put_wr);
        wdata = i_cmd.wipe ? {CH_SPACE, BLANK_COLOR} : {r_char, i_text_color};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[addr] <= wdata;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[addr];
            r_rd_ok   <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_char  <= i_char_code;
            r_lines <= i_scroll_lines;
            r_rrow  <= i_read_row;
            r_rcol  <= i_read_col;
        end
        if (i_cmd.load) begin
            r_o_crow  <= OROW_W'(r_cr);
            r_o_ccol  <= OCOL_W'(r_cc);
            r_o_wtop  <= OROW_W'(r_wt);
            r_o_char  <= r_rd_ok ? r_rd_data[CELL_W-1:COLOR_W] : '0;
            r_o_color <= r_rd_ok ? r_rd_data[COLOR_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr        <= '0;
            r_cc        <= '0;
            r_wt        <= '0;
            r_base      <= '0;
            r_wipe_row  <= '0;
            r_wipe_col  <= '0;
            r_wipe_left <= CNT_W'(R);
        end else begin
            if (i_cmd.exec) begin
                r_cr   <= n_cr;
                r_cc   <= n_cc;
                r_wt   <= n_wt;
                r_base <= n_base;
                if (shift_n != '0) begin
                    r_wipe_row  <= r_base;
                    r_wipe_col  <= '0;
                    r_wipe_left <= wipe_m;
                end
            end
            if (i_cmd.wipe) begin
                if (r_wipe_col == COL_W'(C - 1)) begin
                    r_wipe_col  <= '0;
                    r_wipe_row  <= (r_wipe_row == ROW_W'(R - 1)) ? '0 : r_wipe_row + 1'b1;
                    r_wipe_left <= r_wipe_left - 1'b1;
                end else begin
                    r_wipe_col <= r_wipe_col + 1'b1;
                end
            end
        end
    end

    assign o_cursor_row = r_o_crow;
    assign o_cursor_col = r_o_ccol;
    assign o_window_top = r_o_wtop;
    assign o_cell_char  = r_o_char;
    assign o_cell_color = r_o_color;

endmodule

@@ rtl/text_console_scrollback_engine_unit.sv @@
// Top level of the text console scrollback engine: channels, register port, controller, datapath.
//
// Input channel i_cmd carries one transaction per item: put a byte, scroll the window or only
// read a cell. Output channel o_res returns one result per item: cursor, window top and the
// addressed cell. Both use valid/ready; a transaction moves when both are high. The colour
// register at APB byte address 0 is written by the user only while idle; the block does not check.
//
// An item goes through accept, update, cell store read and result register load, in that
// order. A new transaction is taken only once the previous one has been loaded into the
// result register. The store is a single ring-addressed memory with one access per cycle,
// so an item that frees rows (a scroll past the end of the buffer or a cursor running off
// the last row) also passes a row wipe between update and cell read, one cell cleared per
// cycle. Freed rows are at most SCROLLBACK_ROWS.
// After reset the store is cleared to spaces in colour 0x0f, one cell per cycle, through all
// SCROLLBACK_ROWS * WINDOW_COLS cells (8000 by default); no item is accepted meanwhile,
// register writes are taken as ever.
// A result waits in the output register while the receiver stalls; the next item is still
// accepted and processed, and its result is held back until the register is free.
module text_console_scrollback_engine_unit #(
    parameter int WINDOW_ROWS     = tcse_pkg::DEF_WINDOW_ROWS,
    parameter int WINDOW_COLS     = tcse_pkg::DEF_WINDOW_COLS,
    parameter int SCROLLBACK_ROWS = tcse_pkg::DEF_SCROLLBACK_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tcse_in_if.sink                             i_cmd,
    tcse_out_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcse_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tcse_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tcse_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tcse_pkg::*;

    logic [COLOR_W-1:0] r_text_color;
    logic               cfg_wr, cfg_sel_color;
    t_dp_cmd            cmd;
    t_dp_stat           stat;

    assign pready        = 1'b1;
    assign cfg_sel_color = paddr[CFG_ADDR_W-1] == REG_IDX_TEXT_COLOR;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign prdata        = (psel && cfg_sel_color) ? CFG_DATA_W'(r_text_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= BLANK_COLOR;
        end else if (cfg_wr && cfg_sel_color) begin
            r_text_color <= pwdata[COLOR_W-1:0];
        end
    end

    tcse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    tcse_datapath #(
        .WINDOW_ROWS     (WINDOW_ROWS),
        .WINDOW_COLS     (WINDOW_COLS),
        .SCROLLBACK_ROWS (SCROLLBACK_ROWS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_text_color   (r_text_color),
        .i_kind         (i_cmd.kind),
        .i_char_code    (i_cmd.char_code),
        .i_scroll_lines (i_cmd.scroll_lines),
        .i_read_row     (i_cmd.read_row),
        .i_read_col     (i_cmd.read_col),
        .o_cursor_row   (o_res.cursor_row),
        .o_cursor_col   (o_res.cursor_col),
        .o_window_top   (o_res.window_top),
        .o_cell_char    (o_res.cell_char),
        .o_cell_color   (o_res.cell_color)
    );

endmodule

@@ bench/tcse_console_checker.sv @@
// Console checker: mirrors the scrollback engine state and compares every result transaction.
`timescale 1ns / 1ps
module tcse_console_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcse_in_if                              i_cmd,
    tcse_out_if                             i_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [tcse_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tcse_pkg::CFG_DATA_W-1:0] pwdata,
    output int                              o_mismatches,
    output int                              o_views_due,
    output int                              o_views_checked,
    output int                              o_cursor_row,
    output int                              o_cursor_col
);
    import tcse_pkg::*;

    localparam int ROWS    = DEF_WINDOW_ROWS;
    localparam int COLS    = DEF_WINDOW_COLS;
    localparam int DEPTH   = DEF_SCROLLBACK_ROWS;
    localparam int TOP_MAX = (DEPTH > ROWS) ? DEPTH - ROWS : 0;
    localparam logic [CFG_ADDR_W-1:0] TEXT_COLOR_ADDR = CFG_ADDR_W'(4 * REG_IDX_TEXT_COLOR);

    typedef struct packed {
        logic [OROW_W-1:0]  row;
        logic [OCOL_W-1:0]  col;
        logic [OROW_W-1:0]  top;
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] colour;
    } t_console_view;

    logic [CHAR_W-1:0]  glyph_store  [DEPTH*COLS];
    logic [COLOR_W-1:0] colour_store [DEPTH*COLS];
    logic [COLOR_W-1:0] text_colour;
    int                 cur_row;
    int                 cur_col;
    int                 win_top;
    t_console_view      views_due [$];
    int                 mismatches = 0;
    int                 checked = 0;

    function automatic void clear_console();
        for (int i = 0; i < DEPTH * COLS; i++) begin
            glyph_store[i]  = CH_SPACE;
            colour_store[i] = BLANK_COLOR;
        end
        cur_row     = 0;
        cur_col     = 0;
        win_top     = 0;
        text_colour = BLANK_COLOR;
    endfunction

    function automatic void shift_rows(int n);
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j < COLS; j++) begin
                int d;
                d = i * COLS + j;
                if (n >= DEPTH || i + n >= DEPTH) begin
                    glyph_store[d]  = CH_SPACE;
                    colour_store[d] = BLANK_COLOR;
                end else begin
                    glyph_store[d]  = glyph_store[d + n * COLS];
                    colour_store[d] = colour_store[d + n * COLS];
                end
            end
        end
    endfunction

    function automatic void move_window(int target);
        int excess;
        if (target < 0) begin
            win_top = 0;
            return;
        end
        if (target > TOP_MAX) begin
            excess = target - TOP_MAX;
            shift_rows(excess);
            cur_row = (cur_row > excess) ? cur_row - excess : 0;
            target  = TOP_MAX;
        end
        win_top = target;
    endfunction

    function automatic void next_line();
        cur_row++;
        if (cur_row == win_top + ROWS)
            move_window(win_top + 1);
        // cursor ran off the last buffer row: drop the oldest row, window stays put
        if (cur_row >= DEPTH) begin
            shift_rows(1);
            cur_row = DEPTH - 1;
        end
    endfunction

    function automatic void put_byte(logic [CHAR_W-1:0] c);
        case (c)
            CH_NEWLINE: next_line();
            CH_RETURN: cur_col = 0;
            CH_BACKSPACE: begin
                if (cur_col > 0)
                    cur_col--;
            end
            default: begin
                if (cur_row < DEPTH && cur_col < COLS) begin
                    glyph_store[cur_row * COLS + cur_col]  = c;
                    colour_store[cur_row * COLS + cur_col] = text_colour;
                end
                cur_col++;
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    next_line();
                end
            end
        endcase
    endfunction

    function automatic t_console_view current_view(logic [RROW_W-1:0] r, logic [RCOL_W-1:0] c);
        t_console_view v;
        v.row = OROW_W'(cur_row);
        v.col = OCOL_W'(cur_col);
        v.top = OROW_W'(win_top);
        if (int'(r) < DEPTH && int'(c) < COLS) begin
            v.glyph  = glyph_store[int'(r) * COLS + int'(c)];
            v.colour = colour_store[int'(r) * COLS + int'(c)];
        end else begin
            v.glyph  = '0;
            v.colour = '0;
        end
        return v;
    endfunction

    function automatic void check_field(string label, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", label, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_console_view want;
        if (!i_rst_n) begin
            clear_console();
            views_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == TEXT_COLOR_ADDR)
                text_colour = pwdata[COLOR_W-1:0];
            if (i_res.valid && i_res.ready) begin
                if (views_due.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    want = views_due.pop_front();
                    check_field("cursor_row", want.row, i_res.cursor_row);
                    check_field("cursor_col", want.col, i_res.cursor_col);
                    check_field("window_top", want.top, i_res.window_top);
                    check_field("cell_char", want.glyph, i_res.cell_char);
                    check_field("cell_color", want.colour, i_res.cell_color);
                    checked++;
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.kind)
                    KIND_PUT: put_byte(i_cmd.char_code);
                    KIND_SCROLL: move_window(win_top + int'(i_cmd.scroll_lines));
                    default: ;
                endcase
                views_due.push_back(current_view(i_cmd.read_row, i_cmd.read_col));
            end
        end
        o_mismatches    <= mismatches;
        o_views_due     <= views_due.size();
        o_views_checked <= checked;
        o_cursor_row    <= cur_row;
        o_cursor_col    <= cur_col;
    end

endmodule

@@ bench/tb_text_console_scrollback_engine_unit.sv @@
// Testbench top: clock, reset, stimulus and verdict for the text console scrollback engine.
`timescale 1ns / 1ps
module tb_text_console_scrollback_engine_unit;
    import tcse_pkg::*;

    localparam int LONG_HOLD     = 600;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] TEXT_COLOR_ADDR = CFG_ADDR_W'(4 * REG_IDX_TEXT_COLOR);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int views_due;
    int views_checked;
    int hint_row;
    int hint_col;
    int send_idle;
    int recv_idle;
    bit hold_req;
    int cycle_count = 0;
    int n_sent = 0;
    int n_put = 0;
    int n_scroll = 0;
    int n_read = 0;

    tcse_in_if  cmd_ch ();
    tcse_out_if res_ch ();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    text_console_scrollback_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tcse_console_checker console_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_res           (res_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_mismatches    (mismatches),
        .o_views_due     (views_due),
        .o_views_checked (views_checked),
        .o_cursor_row    (hint_row),
        .o_cursor_col    (hint_col)
    );

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_text_console_scrollback_engine_unit: FAIL");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic offer(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                         input logic signed [LINES_W-1:0] lines,
                         input logic [RROW_W-1:0] row, input logic [RCOL_W-1:0] col);
        while ($urandom_range(0, 99) < send_idle) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.kind         <= kind;
        cmd_ch.char_code    <= ch;
        cmd_ch.scroll_lines <= lines;
        cmd_ch.read_row     <= row;
        cmd_ch.read_col     <= col;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        n_sent++;
        case (kind)
            KIND_PUT: n_put++;
            KIND_SCROLL: n_scroll++;
            default: n_read++;
        endcase
    endtask

    // mostly cells around the cursor, so that fresh writes get read back
    function automatic void pick_cell(output logic [RROW_W-1:0] row,
                                      output logic [RCOL_W-1:0] col);
        int sel;
        int back;
        sel  = $urandom_range(0, 9);
        back = $urandom_range(1, 3);
        if (sel < 4) begin
            row = RROW_W'(hint_row);
            col = RCOL_W'((hint_col >= back) ? hint_col - back : 0);
        end else if (sel < 6) begin
            row = RROW_W'((hint_row > 0) ? hint_row - 1 : 0);
            col = RCOL_W'($urandom_range(0, DEF_WINDOW_COLS - 1));
        end else if (sel < 9) begin
            row = RROW_W'($urandom_range(0, DEF_SCROLLBACK_ROWS - 1));
            col = RCOL_W'($urandom_range(0, DEF_WINDOW_COLS - 1));
        end else begin
            row = RROW_W'($urandom);
            col = RCOL_W'($urandom);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] printable();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE);
        return c;
    endfunction

    task automatic put(input logic [CHAR_W-1:0] ch);
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        pick_cell(row, col);
        offer(KIND_PUT, ch, LINES_W'($urandom), row, col);
    endtask

    task automatic scroll(input logic signed [LINES_W-1:0] lines);
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        pick_cell(row, col);
        offer(KIND_SCROLL, CHAR_W'($urandom), lines, row, col);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (views_due != 0)
            @(posedge i_clk);
    endtask

    task automatic write_colour(input logic [COLOR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_COLOR_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int quota, input bit pressure);
        int first;
        int sel;
        int tail;
        int idle_saved;
        bit held;
        bit paused;
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        first  = n_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (n_sent - first < quota) begin
            if (pressure && !held && n_sent - first >= quota / 3) begin
                // output held off while the sender keeps pushing
                held       = 1'b1;
                idle_saved = send_idle;
                send_idle  = 0;
                hold_req   = 1'b1;
                repeat (40) put(printable());
                send_idle = idle_saved;
            end
            if (pressure && !paused && n_sent - first >= 2 * quota / 3) begin
                paused = 1'b1;
                drain();
            end
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                repeat ($urandom_range(1, 12)) put(printable());
                tail = $urandom_range(0, 9);
                if (tail < 7)
                    put(CH_RETURN);
                if (tail < 9)
                    put(CH_NEWLINE);
            end else if (sel < 35) begin
                repeat ($urandom_range(60, 100)) put(printable());
            end else if (sel < 45) begin
                repeat ($urandom_range(5, 30)) put(CH_NEWLINE);
            end else if (sel < 57) begin
                repeat ($urandom_range(1, 5)) put(CH_BACKSPACE);
                repeat ($urandom_range(1, 4)) put(printable());
            end else if (sel < 72) begin
                scroll(LINES_W'(int'($urandom_range(0, 12)) - 6));
            end else if (sel < 74) begin
                scroll(LINES_W'($urandom));
            end else if (sel < 76) begin
                scroll(LINES_W'(-int'($urandom_range(20, 128))));
            end else if (sel < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    pick_cell(row, col);
                    offer(KIND_READ, CHAR_W'($urandom), LINES_W'($urandom), row, col);
                end
            end else begin
                offer(KIND_W'($urandom), CHAR_W'($urandom), LINES_W'($urandom),
                      RROW_W'($urandom), RCOL_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.kind         <= KIND_READ;
        cmd_ch.char_code    <= '0;
        cmd_ch.scroll_lines <= '0;
        cmd_ch.read_row     <= '0;
        cmd_ch.read_col     <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        send_idle = 32;
        recv_idle = 69;
        hold_req  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_colour(8'h00);
        offer(KIND_READ, 8'h00, 8'sh00, 7'd0, 7'd0);
        offer(KIND_PUT, 8'h00, 8'sh00, 7'd0, 7'd0);
        offer(KIND_PUT, 8'hff, 8'sh7f, 7'd0, 7'd1);
        offer(KIND_PUT, 8'h41, 8'sh80, 7'd0, 7'd2);
        repeat (4) offer(KIND_PUT, CH_BACKSPACE, 8'sh00, 7'd0, 7'd2);
        offer(KIND_PUT, 8'h7e, 8'sh00, 7'd0, 7'd0);
        offer(KIND_PUT, CH_RETURN, 8'sh00, 7'd0, 7'd1);
        offer(KIND_PUT, CH_NEWLINE, 8'sh00, 7'd0, 7'd0);
        offer(KIND_SPARE, 8'hff, 8'sh7f, 7'h7f, 7'h7f);
        offer(KIND_READ, 8'h00, 8'sh00, 7'd99, 7'd79);
        offer(KIND_READ, 8'h00, 8'sh00, 7'd100, 7'd0);
        offer(KIND_READ, 8'h00, 8'sh00, 7'd0, 7'd80);
        offer(KIND_SCROLL, 8'h00, 8'sh80, 7'd1, 7'd0);
        offer(KIND_SCROLL, 8'h00, 8'sd24, 7'd0, 7'd0);
        offer(KIND_SCROLL, 8'h00, 8'sd127, 7'd0, 7'd0);
        offer(KIND_SCROLL, 8'h00, 8'sd127, 7'd99, 7'd79);
        offer(KIND_SCROLL, 8'h00, -8'sd1, 7'd0, 7'd0);
        offer(KIND_SCROLL, 8'h00, 8'sd0, 7'd0, 7'd0);
        offer(KIND_PUT, 8'h55, 8'sd0, 7'd0, 7'd0);
        offer(KIND_SCROLL, 8'h00, -8'sd75, 7'd0, 7'd0);
        drain();

        write_colour(8'hff);
        random_phase(410, 1'b1);
        drain();

        write_colour(COLOR_W'($urandom));
        send_idle = 69;
        recv_idle = 32;
        random_phase(410, 1'b0);
        drain();

        write_colour(COLOR_W'($urandom));
        send_idle = 0;
        recv_idle = 0;
        random_phase(410, 1'b0);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d puts, %0d scrolls, %0d cell reads; %0d results compared",
                 n_sent, n_put, n_scroll, n_read, views_checked);
        $display("Colour register at both extremes and random values, long output stall, drain");
        if (mismatches == 0)
            $display("tb_text_console_scrollback_engine_unit: PASS");
        else
            $display("tb_text_console_scrollback_engine_unit: FAIL");
        $finish;
    end

endmodule
